// File: rtl/pba_pkg.sv
`default_nettype none

package pba_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_SETTLE,
        ST_IDLE,
        ST_SCAN,
        ST_ADDR,
        ST_FREE_MATCH,
        ST_FREE_CHECK,
        ST_FREE_WRITE
    } t_state;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DONE    = 2'd0,
        STATUS_NO_FREE = 2'd1,
        STATUS_IGNORED = 2'd2
    } t_status;

    // Request opcodes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE0 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH0 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE1 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH1 = 3'd4;

    localparam int ADDR_W   = 32;
    localparam int COUNT_W  = 2;
    localparam int STATUS_W = 2;

endpackage

`default_nettype wire

// File: rtl/page_bitmap_allocator.sv
// A free passes through match and check states and, unless ignored, the write state; an
// allocate scans bitmap words region by region, then forms the address in the address state.
// Throughput: one item at a time, set by the bitmap word scan (one RAM read per cycle), up to
// REGIONS * ceil(PAGES_PER_REGION / 32) words (256 with default parameters).
// Reset and each write to a defined register zero the bitmap RAM, one word per cycle, then
// settle; busy stays high meanwhile. The one-cycle result strobe cannot be stalled.
`default_nettype none

module page_bitmap_allocator #(
    parameter int PAGE_SIZE        = 4096,
    parameter int REGIONS          = 2,
    parameter int PAGES_PER_REGION = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_op,
    input  logic [pba_pkg::ADDR_W-1:0]          i_page_address,
    // result channel
    output logic                                o_valid,
    output logic [pba_pkg::ADDR_W-1:0]          o_alloc_address,
    output logic [pba_pkg::STATUS_W-1:0]        o_status,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pba_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pba_pkg::ADDR_W-1:0]          i_cfg_data
);

    // Page geometry: page size is a power of two, so page numbers are shifts.
    localparam int SHIFT = $clog2(PAGE_SIZE);
    localparam int PW    = pba_pkg::ADDR_W - SHIFT;               // page count width
    localparam int WPR   = (PAGES_PER_REGION + 31) / 32;         // bitmap words per region
    localparam int WW    = (WPR > 1) ? $clog2(WPR) : 1;          // word index width
    localparam int NW_W  = $clog2(WPR + 1);                      // word count width
    localparam int MW    = $clog2(PAGES_PER_REGION + 1);         // managed page count width
    localparam int IW    = WW + 5;                               // page index width
    localparam int CW    = ((MW > IW) ? MW : IW) + 1;
    localparam int DEPTH = REGIONS * WPR;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LSW   = pba_pkg::ADDR_W + 8;                  // bitmap page rounding sum

    // ------------------------------------------------------------------
    // Configuration registers. A write to any defined index restarts the
    // clearing sweep; an undefined index is dropped.
    // ------------------------------------------------------------------
    logic [pba_pkg::COUNT_W-1:0] r_count;
    logic [pba_pkg::ADDR_W-1:0]  r_base [2];
    logic [pba_pkg::ADDR_W-1:0]  r_high [2];
    logic                        cfg_hit;

    assign cfg_hit = i_cfg_we && (i_cfg_index <= pba_pkg::REG_HIGH1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_base[0] <= '0;
            r_base[1] <= '0;
            r_high[0] <= '0;
            r_high[1] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pba_pkg::REG_COUNT: r_count   <= i_cfg_data[pba_pkg::COUNT_W-1:0];
                pba_pkg::REG_BASE0: r_base[0] <= i_cfg_data;
                pba_pkg::REG_HIGH0: r_high[0] <= i_cfg_data;
                pba_pkg::REG_BASE1: r_base[1] <= i_cfg_data;
                pba_pkg::REG_HIGH1: r_high[1] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Region geometry, derived in two register stages from the config.
    // The clearing sweep after every write covers both stages, so these
    // are settled before any request is taken.
    // ------------------------------------------------------------------
    logic [PW-1:0]     r_pages   [2];
    logic [PW-1:0]     r_lead    [2];   // bitmap pages at the head of the region
    logic [MW-1:0]     r_managed [2];   // data pages under management
    logic [NW_W-1:0]   r_nwords  [2];   // bitmap words that hold managed pages
    logic              r_active  [2];

    logic [pba_pkg::COUNT_W-1:0] view_limit;
    logic [LSW-1:0]    n_lead_sum [2];
    logic [PW-1:0]     n_lead     [2];
    logic [PW-1:0]     n_data     [2];
    logic [MW-1:0]     n_managed  [2];
    logic [MW:0]       n_words_sum[2];
    logic [NW_W-1:0]   n_nwords   [2];
    logic              n_active   [2];

    assign view_limit = (r_count > pba_pkg::COUNT_W'(REGIONS))
                      ? pba_pkg::COUNT_W'(REGIONS) : r_count;

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            // ceiling of pages over bits per page
            n_lead_sum[r]  = LSW'(r_pages[r]) + LSW'(PAGE_SIZE * 8 - 1);
            n_lead[r]      = PW'(n_lead_sum[r] >> (SHIFT + 3));
            n_data[r]      = r_pages[r] - n_lead[r];
            n_managed[r]   = (33'(n_data[r]) > 33'(PAGES_PER_REGION))
                           ? MW'(PAGES_PER_REGION) : MW'(n_data[r]);
            n_words_sum[r] = (MW + 1)'(n_managed[r]) + (MW + 1)'(31);
            n_nwords[r]    = NW_W'(n_words_sum[r] >> 5);
            n_active[r]    = (pba_pkg::COUNT_W'(r) < view_limit) && (r_pages[r] > PW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 2; r++) begin
            r_pages[r]   <= (r_high[r] > r_base[r])
                          ? PW'((r_high[r] - r_base[r]) >> SHIFT) : '0;
            r_lead[r]    <= n_lead[r];
            r_managed[r] <= n_managed[r];
            r_nwords[r]  <= n_nwords[r];
            r_active[r]  <= n_active[r];
        end
    end

    // ------------------------------------------------------------------
    // Bitmap RAM: one word of used bits per entry, region r at r * WPR.
    // One item is in flight at a time and every write lands before the
    // next read of the same item is issued, so no forwarding is needed.
    // ------------------------------------------------------------------
    logic [31:0]   mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [31:0]   r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_raddr];
        end
    end

    function automatic logic [AW-1:0] word_addr(input logic region, input logic [WW-1:0] word);
        word_addr = (region ? AW'(WPR) : AW'(0)) + AW'(word);
    endfunction

    // ------------------------------------------------------------------
    // Sequencer and datapath registers
    // ------------------------------------------------------------------
    pba_pkg::t_state  r_state, n_state;

    logic                        r_ir,   n_ir;     // region of the next read
    logic [NW_W-1:0]             r_iw,   n_iw;     // word of the next read
    logic                        r_iend, n_iend;   // all words issued
    logic                        r_pv,   n_pv;     // a read is returning this cycle
    logic                        r_pr,   n_pr;     // its region
    logic [WW-1:0]               r_pw,   n_pw;     // its word
    logic                        r_fr,   n_fr;     // region of the chosen page
    logic [IW-1:0]               r_fidx, n_fidx;   // page index within the region
    logic                        r_hit,  n_hit;
    logic [PW-1:0]               r_off,  n_off;
    logic [pba_pkg::ADDR_W-1:0]  r_in_addr, n_in_addr;
    logic [AW-1:0]               r_clr,  n_clr;
    logic                        r_out_vld, n_out_vld;
    logic [pba_pkg::ADDR_W-1:0]  r_out_addr, n_out_addr;
    pba_pkg::t_status            r_out_status, n_out_status;

    // Scan: mask off bits past the managed pages, then take the lowest zero.
    logic [CW-1:0] scan_rem;
    logic          scan_full;
    logic [31:0]   scan_eff;
    logic [31:0]   scan_onehot;
    logic [4:0]    scan_bit;
    logic          scan_found;
    logic          scan_issue;

    assign scan_rem    = CW'(r_managed[r_pr]) - CW'({r_pw, 5'b0});
    assign scan_full   = scan_rem >= CW'(32);
    assign scan_eff    = r_rdata | (scan_full ? 32'h0 : (32'hFFFF_FFFF << scan_rem[4:0]));
    assign scan_onehot = ~scan_eff & (scan_eff + 32'd1);
    assign scan_found  = r_pv && (scan_eff != 32'hFFFF_FFFF);
    assign scan_issue  = !r_iend && r_active[r_ir] && (r_iw < r_nwords[r_ir]);

    always_comb begin
        scan_bit = '0;
        for (int b = 31; b >= 0; b--) begin
            if (!scan_eff[b]) begin
                scan_bit = 5'(b);
            end
        end
    end

    // Free: the first active region strictly containing the address decides.
    logic          fm_aligned;
    logic          fm_hit [2];
    logic [PW-1:0] fm_off [2];
    logic [PW-1:0] fc_idx;
    logic          fc_ignore;

    assign fm_aligned = (r_in_addr[SHIFT-1:0] == '0);

    always_comb begin
        for (int r = 0; r < 2; r++) begin
            fm_hit[r] = r_active[r] && (r_high[r] > r_in_addr) && (r_in_addr > r_base[r]);
            fm_off[r] = PW'((r_in_addr - r_base[r]) >> SHIFT);
        end
    end

    assign fc_idx    = r_off - r_lead[r_fr];
    assign fc_ignore = !r_hit || (r_off < r_lead[r_fr])
                    || (33'(fc_idx) >= 33'(r_managed[r_fr]));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pba_pkg::ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = pba_pkg::ST_SETTLE;
                end
            end
            pba_pkg::ST_SETTLE: n_state = pba_pkg::ST_IDLE;
            pba_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = (i_op == pba_pkg::OP_ALLOC) ? pba_pkg::ST_SCAN
                                                          : pba_pkg::ST_FREE_MATCH;
                end
            end
            pba_pkg::ST_SCAN: begin
                if (scan_found) begin
                    n_state = pba_pkg::ST_ADDR;
                end else if (!r_pv && r_iend) begin
                    n_state = pba_pkg::ST_IDLE;
                end
            end
            pba_pkg::ST_ADDR:       n_state = pba_pkg::ST_IDLE;
            pba_pkg::ST_FREE_MATCH: n_state = pba_pkg::ST_FREE_CHECK;
            pba_pkg::ST_FREE_CHECK: begin
                n_state = fc_ignore ? pba_pkg::ST_IDLE : pba_pkg::ST_FREE_WRITE;
            end
            pba_pkg::ST_FREE_WRITE: n_state = pba_pkg::ST_IDLE;
            default:                n_state = pba_pkg::ST_CLEAR;
        endcase
        if (cfg_hit) begin
            n_state = pba_pkg::ST_CLEAR;
        end
    end

    // Datapath and RAM control
    always_comb begin
        mem_we       = 1'b0;
        mem_waddr    = word_addr(r_pr, r_pw);
        mem_wdata    = r_rdata | scan_onehot;
        mem_re       = 1'b0;
        mem_raddr    = word_addr(r_ir, r_iw[WW-1:0]);
        n_ir         = r_ir;
        n_iw         = r_iw;
        n_iend       = r_iend;
        n_pv         = 1'b0;
        n_pr         = r_pr;
        n_pw         = r_pw;
        n_fr         = r_fr;
        n_fidx       = r_fidx;
        n_hit        = r_hit;
        n_off        = r_off;
        n_in_addr    = r_in_addr;
        n_clr        = r_clr;
        n_out_vld    = 1'b0;
        n_out_addr   = '0;
        n_out_status = pba_pkg::STATUS_DONE;

        case (r_state)
            pba_pkg::ST_CLEAR: begin
                // zero one bitmap word per cycle
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            pba_pkg::ST_IDLE: begin
                n_in_addr = i_page_address;
                n_ir      = 1'b0;
                n_iw      = '0;
                n_iend    = 1'b0;
            end
            pba_pkg::ST_SCAN: begin
                if (scan_found) begin
                    // set the bit and hold the page index for the address stage
                    mem_we = 1'b1;
                    n_fr   = r_pr;
                    n_fidx = {r_pw, scan_bit};
                end else if (!r_pv && r_iend) begin
                    n_out_vld    = 1'b1;
                    n_out_status = pba_pkg::STATUS_NO_FREE;
                end else begin
                    n_pv = scan_issue;
                    n_pr = r_ir;
                    n_pw = r_iw[WW-1:0];
                    if (scan_issue) begin
                        mem_re = 1'b1;
                        n_iw   = r_iw + NW_W'(1);
                    end else if (!r_iend) begin
                        // advance to the next region, or end the walk
                        if (r_ir == 1'(REGIONS - 1)) begin
                            n_iend = 1'b1;
                        end else begin
                            n_ir = r_ir + 1'b1;
                            n_iw = '0;
                        end
                    end
                end
            end
            pba_pkg::ST_ADDR: begin
                n_out_vld  = 1'b1;
                n_out_addr = r_base[r_fr]
                           + ((pba_pkg::ADDR_W'(r_lead[r_fr]) + pba_pkg::ADDR_W'(r_fidx))
                              << SHIFT);
            end
            pba_pkg::ST_FREE_MATCH: begin
                n_hit = fm_aligned && (fm_hit[0] || fm_hit[1]);
                n_fr  = !fm_hit[0];
                n_off = fm_hit[0] ? fm_off[0] : fm_off[1];
            end
            pba_pkg::ST_FREE_CHECK: begin
                n_fidx = IW'(fc_idx);
                if (fc_ignore) begin
                    n_out_vld    = 1'b1;
                    n_out_status = pba_pkg::STATUS_IGNORED;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = word_addr(r_fr, fc_idx[IW-1:5]);
                end
            end
            pba_pkg::ST_FREE_WRITE: begin
                // clear the bit; a page already free stays free
                mem_we    = 1'b1;
                mem_waddr = word_addr(r_fr, r_fidx[IW-1:5]);
                mem_wdata = r_rdata & ~(32'd1 << r_fidx[4:0]);
                n_out_vld = 1'b1;
            end
            default: ;
        endcase

        if (cfg_hit) begin
            n_clr = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pba_pkg::ST_CLEAR;
            r_clr     <= '0;
            r_out_vld <= 1'b0;
            r_pv      <= 1'b0;
            r_iend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_out_vld <= n_out_vld;
            r_pv      <= n_pv;
            r_iend    <= n_iend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ir         <= n_ir;
        r_iw         <= n_iw;
        r_pr         <= n_pr;
        r_pw         <= n_pw;
        r_fr         <= n_fr;
        r_fidx       <= n_fidx;
        r_hit        <= n_hit;
        r_off        <= n_off;
        r_in_addr    <= n_in_addr;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    assign busy            = (r_state != pba_pkg::ST_IDLE);
    assign o_valid         = r_out_vld;
    assign o_alloc_address = r_out_addr;
    assign o_status        = r_out_status;

endmodule

`default_nettype wire

// File: tb/sv/page_bitmap_allocator_tb.sv
`default_nettype none

module page_bitmap_allocator_tb;

    localparam int PAGE_BYTES       = 4096;
    localparam int NREG             = 2;
    localparam int PAGES_PER_REGION = 4096;
    // one bitmap page covers this many pages
    localparam int MAP_PAGE_SPAN    = PAGE_BYTES * 8;

    localparam int RANDOM_ITEMS = 400;
    // the last transfers of the run go without sender gaps
    localparam int CALM_ITEMS   = 60;
    // outlasts the worst allocate scan plus a full bitmap sweep
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 16;

    // an index past the register file: the write must change nothing
    localparam logic [pba_pkg::CFG_INDEX_W-1:0] REG_NONE = 3'd7;

    typedef struct {
        bit          active;
        logic [31:0] base;
        logic [31:0] lead;     // bitmap pages at the head of the region
        logic [31:0] managed;  // data pages that carry a used bit
    } t_layout;

    typedef struct {
        logic [31:0]      address;
        pba_pkg::t_status status;
    } t_grant;

    // ROW_CHK carries a result typed in by hand, ROW_REQ takes the predicted one
    typedef enum {ROW_CFG, ROW_REQ, ROW_CHK} t_row_kind;

    typedef struct {
        t_row_kind                         kind;
        logic [pba_pkg::CFG_INDEX_W-1:0]   index;
        logic                              op;
        logic [31:0]                       value;
        logic [31:0]                       exp_address;
        pba_pkg::t_status                  exp_status;
    } t_plan_row;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic                              i_op;
    logic [pba_pkg::ADDR_W-1:0]        i_page_address;
    logic                              o_valid;
    logic [pba_pkg::ADDR_W-1:0]        o_alloc_address;
    logic [pba_pkg::STATUS_W-1:0]      o_status;
    logic                              i_cfg_we;
    logic [pba_pkg::CFG_INDEX_W-1:0]   i_cfg_index;
    logic [pba_pkg::ADDR_W-1:0]        i_cfg_data;

    // shadow copy of the allocator: region registers and the used bits
    logic [1:0]  lay_count;
    logic [31:0] lay_base [NREG];
    logic [31:0] lay_high [NREG];
    bit          used_map [NREG][PAGES_PER_REGION];

    t_grant      pending_grants[$];
    logic [31:0] live_pages[$];     // pages handed out and not yet given back
    int          mismatches;
    int          stall_cycles;

    page_bitmap_allocator #(
        .PAGE_SIZE        (PAGE_BYTES),
        .REGIONS          (NREG),
        .PAGES_PER_REGION (PAGES_PER_REGION)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_op            (i_op),
        .i_page_address  (i_page_address),
        .o_valid         (o_valid),
        .o_alloc_address (o_alloc_address),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Directed opening: empty allocator, exhaustion over two small regions, every
    // kind of ignored free, oversized region count, a region big enough to clip at
    // capacity, a write to a missing register, degenerate and inverted regions.
    t_plan_row opening_plan [0:37] = '{
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_NO_FREE},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h0000_1000, 32'h0000_0000,
          pba_pkg::STATUS_IGNORED},
        '{ROW_CFG, pba_pkg::REG_COUNT, pba_pkg::OP_ALLOC, 32'h0000_0002, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, pba_pkg::REG_BASE0, pba_pkg::OP_ALLOC, 32'h1000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, pba_pkg::REG_HIGH0, pba_pkg::OP_ALLOC, 32'h1000_4000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, pba_pkg::REG_BASE1, pba_pkg::OP_ALLOC, 32'h2000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, pba_pkg::REG_HIGH1, pba_pkg::OP_ALLOC, 32'h2000_2000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        // region 0 holds three data pages, region 1 one
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_NO_FREE},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h1000_2000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h1000_2000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        // freeing a page twice still reports done
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h1000_2000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h1000_2800, 32'h0000_0000,
          pba_pkg::STATUS_IGNORED},
        // base and high themselves fall outside the strict range
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h1000_0000, 32'h0000_0000,
          pba_pkg::STATUS_IGNORED},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h1000_4000, 32'h0000_0000,
          pba_pkg::STATUS_IGNORED},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'hFFFF_F000, 32'h0000_0000,
          pba_pkg::STATUS_IGNORED},
        // count of three acts as two, and the write wipes the bitmap
        '{ROW_CFG, pba_pkg::REG_COUNT, pba_pkg::OP_ALLOC, 32'h0000_0003, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        // nearly all of memory: 32 bitmap pages, data clipped at capacity
        '{ROW_CFG, pba_pkg::REG_BASE0, pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, pba_pkg::REG_HIGH0, pba_pkg::OP_ALLOC, 32'hFFFF_F000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h0001_F000, 32'h0000_0000,
          pba_pkg::STATUS_IGNORED},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h0102_0000, 32'h0000_0000,
          pba_pkg::STATUS_IGNORED},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_FREE,  32'h0101_F000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, REG_NONE,           pba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        // a single page region drops out
        '{ROW_CFG, pba_pkg::REG_HIGH0, pba_pkg::OP_ALLOC, 32'h0000_1FFF, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, pba_pkg::REG_BASE1, pba_pkg::OP_ALLOC, 32'hFFFF_C000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CFG, pba_pkg::REG_HIGH1, pba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_REQ, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        // high below base leaves no region at all
        '{ROW_CFG, pba_pkg::REG_HIGH1, pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_DONE},
        '{ROW_CHK, REG_NONE,           pba_pkg::OP_ALLOC, 32'h0000_0000, 32'h0000_0000,
          pba_pkg::STATUS_NO_FREE}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("MISMATCH %0t: %s", $time, what);
        mismatches++;
    endtask

    // Work out the bitmap and data page split of one region.
    function automatic t_layout region_layout(input int r);
        t_layout     v;
        logic [31:0] pages;
        int          lim;
        lim       = (lay_count > NREG) ? NREG : int'(lay_count);
        v.active  = 1'b0;
        v.base    = lay_base[r];
        v.lead    = '0;
        v.managed = '0;
        pages     = '0;
        if (r >= lim) return v;
        if (lay_high[r] > v.base) pages = (lay_high[r] - v.base) / PAGE_BYTES;
        if (pages <= 1) return v;
        v.active  = 1'b1;
        v.lead    = pages / MAP_PAGE_SPAN + ((pages % MAP_PAGE_SPAN != 0) ? 1 : 0);
        v.managed = pages - v.lead;
        if (v.managed > PAGES_PER_REGION) v.managed = PAGES_PER_REGION;
        return v;
    endfunction

    // Mirror a register write; a real register wipes every used bit.
    function automatic void apply_register(input logic [pba_pkg::CFG_INDEX_W-1:0] idx,
                                           input logic [31:0] value);
        case (idx)
            pba_pkg::REG_COUNT: lay_count   = value[1:0];
            pba_pkg::REG_BASE0: lay_base[0] = value;
            pba_pkg::REG_HIGH0: lay_high[0] = value;
            pba_pkg::REG_BASE1: lay_base[1] = value;
            pba_pkg::REG_HIGH1: lay_high[1] = value;
            default: return;
        endcase
        foreach (used_map[r, i]) used_map[r][i] = 1'b0;
        live_pages.delete();
    endfunction

    // Serve one request against the shadow bitmap and return the result it yields.
    function automatic t_grant serve_request(input logic op, input logic [31:0] addr);
        t_grant      g;
        t_layout     v;
        logic [31:0] off;
        g.address = '0;
        if (op == pba_pkg::OP_ALLOC) begin
            g.status = pba_pkg::STATUS_NO_FREE;
            for (int r = 0; r < NREG; r++) begin
                v = region_layout(r);
                if (!v.active) continue;
                for (int i = 0; i < v.managed; i++) begin
                    if (!used_map[r][i]) begin
                        used_map[r][i] = 1'b1;
                        g.address = v.base + (v.lead + 32'(i)) * 32'(PAGE_BYTES);
                        g.status  = pba_pkg::STATUS_DONE;
                        return g;
                    end
                end
            end
            return g;
        end
        g.status = pba_pkg::STATUS_IGNORED;
        if (addr % PAGE_BYTES != 0) return g;
        // first region whose open interval holds the address decides
        for (int r = 0; r < NREG; r++) begin
            v = region_layout(r);
            if (!v.active) continue;
            if (!(lay_high[r] > addr && addr > v.base)) continue;
            off = (addr - v.base) / PAGE_BYTES;
            if (off < v.lead) return g;
            off = off - v.lead;
            if (off >= v.managed) return g;
            used_map[r][off] = 1'b0;
            g.status = pba_pkg::STATUS_DONE;
            return g;
        end
        return g;
    endfunction

    // Hold start until the block takes the transfer, then queue its result.
    // Called in the step of a rising edge; leaves start high.
    task automatic send_item(input logic op, input logic [31:0] addr,
                             input bit typed, input t_grant typed_grant);
        t_grant g;
        start          <= 1'b1;
        i_op           <= op;
        i_page_address <= addr;
        do @(posedge i_clk); while (busy);
        g = serve_request(op, addr);
        if (op == pba_pkg::OP_ALLOC && g.status == pba_pkg::STATUS_DONE)
            live_pages.push_back(g.address);
        pending_grants.push_back(typed ? typed_grant : g);
    endtask

    // Write one register once the block is idle and every result is in.
    task automatic write_register(input logic [pba_pkg::CFG_INDEX_W-1:0] idx,
                                  input logic [31:0] value);
        start <= 1'b0;
        do @(posedge i_clk); while (busy || pending_grants.size() != 0);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        apply_register(idx, value);
    endtask

    // Draw region bounds: mostly small regions, some near or far past capacity,
    // some empty or inverted, some fully random.
    function automatic void pick_bounds(output logic [31:0] lo, output logic [31:0] hi);
        int unsigned kind;
        logic [31:0] pages;
        kind = $urandom_range(0, 9);
        lo   = $urandom & ~32'(PAGE_BYTES - 1);
        if (kind <= 5) begin
            pages = $urandom_range(0, 40);
            hi    = lo + pages * PAGE_BYTES;
            if (kind == 5) hi = hi + $urandom_range(1, PAGE_BYTES - 1);
        end else if (kind <= 7) begin
            lo    = $urandom_range(0, 255) * PAGE_BYTES;
            pages = (kind == 6) ? $urandom_range(PAGES_PER_REGION - 8, PAGES_PER_REGION + 40)
                                : $urandom_range(PAGES_PER_REGION, (1 << 20) - 256);
            hi    = lo + pages * PAGE_BYTES;
        end else if (kind == 8) begin
            hi = lo - $urandom_range(0, 3) * PAGE_BYTES;
        end else begin
            lo = $urandom;
            hi = $urandom;
        end
    endfunction

    task automatic program_random_layout();
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned pick;
        // bias the count toward one or two live regions
        pick = $urandom_range(0, 9);
        write_register(pba_pkg::REG_COUNT, (pick == 0) ? 32'd0 : (pick == 1) ? 32'd3 :
                                           (pick < 6) ? 32'd2 : 32'd1);
        pick_bounds(lo, hi);
        write_register(pba_pkg::REG_BASE0, lo);
        write_register(pba_pkg::REG_HIGH0, hi);
        pick_bounds(lo, hi);
        write_register(pba_pkg::REG_BASE1, lo);
        write_register(pba_pkg::REG_HIGH1, hi);
    endtask

    // Check each result against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_valid) begin
            if (pending_grants.size() == 0) begin
                flag_mismatch($sformatf("unexpected result address %h status %0d",
                                        o_alloc_address, o_status));
            end else begin
                want = pending_grants.pop_front();
                if (o_alloc_address !== want.address)
                    flag_mismatch($sformatf("address %h, want %h", o_alloc_address,
                                            want.address));
                if (o_status !== want.status)
                    flag_mismatch($sformatf("status %0d, want %0d", o_status, want.status));
            end
        end
    end

    // Drop the run when nothing has moved for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid || i_cfg_we) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        t_grant      typed_grant;
        t_grant      no_grant;
        t_layout     lay;
        logic [31:0] addr;
        logic        op;
        int          sent;
        int          burst;
        int          pick;
        int          slot;
        int          span;
        int          r;
        bit          quiet_phase;

        mismatches   = 0;
        stall_cycles = 0;
        no_grant     = '{address: '0, status: pba_pkg::STATUS_DONE};
        lay_count    = '0;
        lay_base     = '{default: '0};
        lay_high     = '{default: '0};
        foreach (used_map[rr, i]) used_map[rr][i] = 1'b0;

        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_op           <= pba_pkg::OP_ALLOC;
        i_page_address <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_index    <= pba_pkg::REG_COUNT;
        i_cfg_data     <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (opening_plan[n]) begin
            if (opening_plan[n].kind == ROW_CFG) begin
                write_register(opening_plan[n].index, opening_plan[n].value);
            end else begin
                typed_grant.address = opening_plan[n].exp_address;
                typed_grant.status  = opening_plan[n].exp_status;
                send_item(opening_plan[n].op, opening_plan[n].value,
                          opening_plan[n].kind == ROW_CHK, typed_grant);
            end
        end

        // random phases: fresh layout, then a burst of allocate and free traffic
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            program_random_layout();
            burst       = $urandom_range(25, 50);
            quiet_phase = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                addr = $urandom;
                op   = pba_pkg::OP_ALLOC;
                if (pick >= 50) begin
                    op = pba_pkg::OP_FREE;
                    if (pick < 78 && live_pages.size() != 0) begin
                        // give back a page that is out
                        slot = $urandom_range(0, live_pages.size() - 1);
                        addr = live_pages[slot];
                        live_pages.delete(slot);
                    end else if (pick < 90) begin
                        // aligned address near or inside a region, bitmap pages included
                        r    = $urandom_range(0, NREG - 1);
                        lay  = region_layout(r);
                        span = $urandom_range(0, 1) ? int'(lay.lead + lay.managed) + 1 : 40;
                        addr = lay_base[r] + $urandom_range(0, span) * PAGE_BYTES;
                    end else if (pick < 95) begin
                        addr = (addr & ~32'(PAGE_BYTES - 1)) | $urandom_range(1, PAGE_BYTES - 1);
                    end
                end
                send_item(op, addr, 1'b0, no_grant);
                sent++;
                // sender gap, none in the calm tail
                if (!quiet_phase && sent < RANDOM_ITEMS - CALM_ITEMS &&
                    $urandom_range(0, 2) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 15)) @(posedge i_clk);
                end
            end
        end
        start <= 1'b0;

        // drain, then let the block settle
        do @(posedge i_clk); while (pending_grants.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_grants.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_grants.size()));

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/pba_pkg.sv
rtl/page_bitmap_allocator.sv
tb/sv/page_bitmap_allocator_tb.sv
